// ----- src/tpc_pkg.sv -----
// Shared constants for the two-point calibration datapath.
package tpc_pkg;

    // Slope scale, signed so it multiplies signed operands directly.
    localparam logic signed [17:0] GAIN_SCALE  = 18'sd100000;
    // Offset rescale divisor and rounding threshold.
    localparam int                 OFFSET_DIV  = 10000;
    localparam int                 OFFSET_HALF = 5000;
    localparam int                 OFFSET_DW   = 14;    // bits to hold a remainder of OFFSET_DIV

    // Reciprocal of OFFSET_DIV, exact for dividends below 10000 * 2^16:
    // q = (v * OFFSET_RECIP) >> OFFSET_SHIFT
    localparam logic [30:0]        OFFSET_RECIP = 31'd1759218605;
    localparam int                 OFFSET_SHIFT = 44;

    // Magnitude widths of the slope division.
    localparam int                 NUM_W       = 50;    // |y1-y2|*100000 < 2^49
    localparam int                 DEN_W       = 32;    // |x1-x2| < 2^32

endpackage

// ----- src/tpc_udiv_pipe.sv -----
// Pipelined restoring unsigned divider, one quotient bit per stage.
module tpc_udiv_pipe #(
    parameter int NW = 64,
    parameter int DW = 32,
    parameter int SW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    output logic [NW-1:0] o_quo,
    output logic [DW-1:0] o_rem,
    output logic [SW-1:0] o_side
);

    logic [NW-1:0] r_vld;
    logic [DW-1:0] r_rem  [NW];
    logic [NW-1:0] r_nq   [NW];
    logic [DW-1:0] r_den  [NW];
    logic [SW-1:0] r_side [NW];

    // stage inputs
    logic          a_vld  [NW];
    logic [DW-1:0] a_rem  [NW];
    logic [NW-1:0] a_nq   [NW];
    logic [DW-1:0] a_den  [NW];
    logic [SW-1:0] a_side [NW];

    // stage results
    logic [DW-1:0] n_rem  [NW];
    logic [NW-1:0] n_nq   [NW];

    always_comb begin
        a_vld[0]  = i_valid;
        a_rem[0]  = '0;
        a_nq[0]   = i_num;
        a_den[0]  = i_den;
        a_side[0] = i_side;
        for (int k = 1; k < NW; k++) begin
            a_vld[k]  = r_vld[k-1];
            a_rem[k]  = r_rem[k-1];
            a_nq[k]   = r_nq[k-1];
            a_den[k]  = r_den[k-1];
            a_side[k] = r_side[k-1];
        end
    end

    always_comb begin
        logic [DW:0] v_trial;
        logic [DW:0] v_diff;
        logic        v_bit;
        for (int k = 0; k < NW; k++) begin
            v_trial = {a_rem[k], a_nq[k][NW-1]};
            v_diff  = v_trial - {1'b0, a_den[k]};
            v_bit   = (v_trial >= {1'b0, a_den[k]});
            n_rem[k] = v_bit ? v_diff[DW-1:0] : v_trial[DW-1:0];
            n_nq[k]  = {a_nq[k][NW-2:0], v_bit};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            for (int k = 0; k < NW; k++) begin
                r_vld[k] <= a_vld[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < NW; k++) begin
                r_rem[k]  <= n_rem[k];
                r_nq[k]   <= n_nq[k];
                r_den[k]  <= a_den[k];
                r_side[k] <= a_side[k];
            end
        end
    end

    assign o_valid = r_vld[NW-1];
    assign o_quo   = r_nq[NW-1];
    assign o_rem   = r_rem[NW-1];
    assign o_side  = r_side[NW-1];

endmodule

// ----- src/two_point_calibration_fixed.sv -----
// Two-point linear calibration: gain and offset from two (reading, target) pairs.
//
// Usage:
//   Slave stream carries one calibration pair per word; master stream returns
//   gain (slope * 100000) and offset (intercept * 10), both low 32 bits.
//   A degenerate span (equal readings, or span of one) is patched before use.
// Throughput: one word per cycle, sustained while the master does not stall, with no
//   bubbles between words.
// Pipeline: 66 register stages: 3 prep stages, 50 stages of the slope divider
//   (one quotient bit each), 4 stages for slope fixup, split 64-bit multiply,
//   sum and magnitude, 8 stages of the divide by 10000 (four 16-bit digits,
//   each a reciprocal multiply stage and a remainder stage), then the output
//   register.
// Stall: every stage advances only while the output register is empty or
//   being taken, so o_s_axis_tready drops with a stalled master and nothing
//   is dropped or repeated; the output word holds until taken.
// Reset: synchronous, active low; clears all valid bits, so the pipe is
//   empty and ready on the first cycle after reset.
module two_point_calibration_fixed (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // [31:0] first_target, [63:32] first_reading,
    // [95:64] second_target, [127:96] second_reading
    input  logic [127:0] i_s_axis_tdata,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // [31:0] gain_scaled, [63:32] offset_scaled
    output logic [63:0]  o_m_axis_tdata
);

    localparam int NW1 = tpc_pkg::NUM_W;
    localparam int DW1 = tpc_pkg::DEN_W;
    localparam int SW1 = 1 + 64 + 34 + DW1;
    localparam int DW2 = tpc_pkg::OFFSET_DW;
    localparam int VW2 = DW2 + 16;       // remainder in front of one 16-bit digit
    localparam int ND  = 4;              // 16-bit digits of the 64-bit magnitude

    // whole pipe moves together; output reg is the last stage
    logic w_en;
    logic r_o_vld;
    assign w_en            = !r_o_vld || i_m_axis_tready;
    assign o_s_axis_tready = w_en;

    // ---- stage A: unpack, span patch
    logic signed [33:0] w_x1, w_x2, w_d0, w_y1, w_y2;
    logic signed [33:0] n_a_d, n_a_x2;
    assign w_y1 = 34'($signed(i_s_axis_tdata[31:0]));
    assign w_x1 = 34'($signed(i_s_axis_tdata[63:32]));
    assign w_y2 = 34'($signed(i_s_axis_tdata[95:64]));
    assign w_x2 = 34'($signed(i_s_axis_tdata[127:96]));
    assign w_d0 = w_x1 - w_x2;

    always_comb begin
        if (w_d0 == 34'sd0) begin
            // equal readings: x2 = x1 - 2
            n_a_d  = 34'sd2;
            n_a_x2 = w_x1 - 34'sd2;
        end else if (w_d0 == 34'sd1 || w_d0 == -34'sd1) begin
            // half-span would truncate to zero: x2 = x1 - 3
            n_a_d  = 34'sd3;
            n_a_x2 = w_x1 - 34'sd3;
        end else begin
            n_a_d  = w_d0;
            n_a_x2 = w_x2;
        end
    end

    logic               r_a_vld;
    logic signed [33:0] r_a_d, r_a_x2, r_a_yd;
    logic signed [31:0] r_a_y2;

    // ---- stage B: scale target delta, span magnitude
    logic signed [51:0] n_b_t;
    logic signed [63:0] n_b_y2s;
    logic [33:0]        w_b_dneg;
    assign n_b_t    = r_a_yd * tpc_pkg::GAIN_SCALE;
    assign n_b_y2s  = r_a_y2 * tpc_pkg::GAIN_SCALE;
    assign w_b_dneg = -r_a_d;

    logic               r_b_vld;
    logic signed [51:0] r_b_t;
    logic               r_b_dsgn;
    logic [DW1-1:0]     r_b_dmag;
    logic signed [63:0] r_b_y2s;
    logic signed [33:0] r_b_x2;

    // ---- stage C: dividend magnitude, quotient sign
    logic [51:0] w_c_tneg;
    assign w_c_tneg = -r_b_t;

    logic               r_c_vld;
    logic [NW1-1:0]     r_c_tmag;
    logic               r_c_sgn;
    logic [DW1-1:0]     r_c_dmag;
    logic signed [63:0] r_c_y2s;
    logic signed [33:0] r_c_x2;

    // ---- slope divider
    logic           w_d1_vld;
    logic [NW1-1:0] w_d1_quo;
    logic [DW1-1:0] w_d1_rem;
    logic [SW1-1:0] w_d1_side;
    logic           w_d1_sgn;
    logic [63:0]    w_d1_y2s;
    logic [33:0]    w_d1_x2;
    logic [DW1-1:0] w_d1_dmag;
    assign {w_d1_sgn, w_d1_y2s, w_d1_x2, w_d1_dmag} = w_d1_side;

    tpc_udiv_pipe #(.NW(NW1), .DW(DW1), .SW(SW1)) u_div_slope (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_c_vld),
        .i_num   (r_c_tmag),
        .i_den   (r_c_dmag),
        .i_side  ({r_c_sgn, r_c_y2s, r_c_x2, r_c_dmag}),
        .o_valid (w_d1_vld),
        .o_quo   (w_d1_quo),
        .o_rem   (w_d1_rem),
        .o_side  (w_d1_side)
    );

    // ---- stage E: remainder over half-span adds 0..2, apply sign
    logic [DW1-1:0] w_e_h, w_e_h2;
    logic [1:0]     w_e_q2;
    logic [63:0]    w_e_mag;
    assign w_e_h   = {1'b0, w_d1_dmag[DW1-1:1]};
    assign w_e_h2  = {w_d1_dmag[DW1-1:1], 1'b0};
    assign w_e_q2  = (w_d1_rem >= w_e_h2) ? 2'd2 : ((w_d1_rem >= w_e_h) ? 2'd1 : 2'd0);
    assign w_e_mag = 64'(w_d1_quo) + 64'(w_e_q2);

    logic        r_e_vld;
    logic [63:0] r_e_s;
    logic [63:0] r_e_y2s;
    logic [33:0] r_e_x2;

    // ---- stage F: low 64 bits of s * x2 as 32x32 partial products
    logic [63:0] w_f_b;
    logic [63:0] w_f_p0, w_f_p1, w_f_p2;
    assign w_f_b  = 64'($signed(r_e_x2));
    assign w_f_p0 = r_e_s[31:0]  * w_f_b[31:0];
    assign w_f_p1 = r_e_s[31:0]  * w_f_b[63:32];
    assign w_f_p2 = r_e_s[63:32] * w_f_b[31:0];

    logic        r_f_vld;
    logic [63:0] r_f_p0;
    logic [31:0] r_f_p1, r_f_p2;
    logic [63:0] r_f_y2s;
    logic [31:0] r_f_s;

    // ---- stage G: intercept numerator, wraps mod 2^64
    logic [63:0] n_g_u;
    assign n_g_u = r_f_y2s - (r_f_p0 + {r_f_p1 + r_f_p2, 32'd0});

    logic        r_g_vld;
    logic [63:0] r_g_u;
    logic [31:0] r_g_s;

    // ---- stage H: magnitude for the divide by 10000
    logic        r_h_vld;
    logic [63:0] r_h_umag;
    logic        r_h_usgn;
    logic [31:0] r_h_s;

    // ---- offset divide by 10000: long division on 16-bit digits, top first.
    //      P stage: digit quotient by reciprocal multiply.
    //      R stage: digit remainder, quotient shifted in (low 32 bits kept).
    logic           w_q_vld  [ND];
    logic [DW2-1:0] w_q_rin  [ND];
    logic [63:0]    w_q_num  [ND];
    logic [31:0]    w_q_quo  [ND];
    logic           w_q_sgn  [ND];
    logic [31:0]    w_q_s    [ND];
    logic [VW2-1:0] w_q_v    [ND];
    logic [60:0]    w_q_prod [ND];
    logic [VW2-1:0] w_r_sub  [ND];

    logic           r_p_vld  [ND];
    logic [VW2-1:0] r_p_v    [ND];
    logic [15:0]    r_p_q    [ND];
    logic [63:0]    r_p_num  [ND];
    logic [31:0]    r_p_quo  [ND];
    logic           r_p_sgn  [ND];
    logic [31:0]    r_p_s    [ND];

    logic           r_r_vld  [ND];
    logic [DW2-1:0] r_r_rem  [ND];
    logic [63:0]    r_r_num  [ND];
    logic [31:0]    r_r_quo  [ND];
    logic           r_r_sgn  [ND];
    logic [31:0]    r_r_s    [ND];

    always_comb begin
        w_q_vld[0] = r_h_vld;
        w_q_rin[0] = '0;
        w_q_num[0] = r_h_umag;
        w_q_quo[0] = '0;
        w_q_sgn[0] = r_h_usgn;
        w_q_s[0]   = r_h_s;
        for (int k = 1; k < ND; k++) begin
            w_q_vld[k] = r_r_vld[k-1];
            w_q_rin[k] = r_r_rem[k-1];
            w_q_num[k] = r_r_num[k-1];
            w_q_quo[k] = r_r_quo[k-1];
            w_q_sgn[k] = r_r_sgn[k-1];
            w_q_s[k]   = r_r_s[k-1];
        end
        for (int k = 0; k < ND; k++) begin
            // remainder < 10000 in front of the digit keeps v below 10000 * 2^16
            w_q_v[k]    = {w_q_rin[k], w_q_num[k][63-16*k -: 16]};
            w_q_prod[k] = 61'(w_q_v[k]) * 61'(tpc_pkg::OFFSET_RECIP);
            w_r_sub[k]  = r_p_v[k] - 30'(r_p_q[k]) * 30'(tpc_pkg::OFFSET_DIV);
        end
    end

    // ---- output: round on remainder, apply sign, low 32 bits
    logic [31:0] w_o_mag, n_o_off;
    assign w_o_mag = r_r_quo[ND-1]
                   + 32'(r_r_rem[ND-1] >= DW2'(tpc_pkg::OFFSET_HALF));
    assign n_o_off = r_r_sgn[ND-1] ? -w_o_mag : w_o_mag;

    logic [31:0] r_o_gain, r_o_off;

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_e_vld <= 1'b0;
            r_f_vld <= 1'b0;
            r_g_vld <= 1'b0;
            r_h_vld <= 1'b0;
            for (int k = 0; k < ND; k++) begin
                r_p_vld[k] <= 1'b0;
                r_r_vld[k] <= 1'b0;
            end
            r_o_vld <= 1'b0;
        end else if (w_en) begin
            r_a_vld <= i_s_axis_tvalid;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
            r_e_vld <= w_d1_vld;
            r_f_vld <= r_e_vld;
            r_g_vld <= r_f_vld;
            r_h_vld <= r_g_vld;
            for (int k = 0; k < ND; k++) begin
                r_p_vld[k] <= w_q_vld[k];
                r_r_vld[k] <= r_p_vld[k];
            end
            r_o_vld <= r_r_vld[ND-1];
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_d    <= n_a_d;
            r_a_x2   <= n_a_x2;
            r_a_yd   <= w_y1 - w_y2;
            r_a_y2   <= w_y2[31:0];

            r_b_t    <= n_b_t;
            r_b_dsgn <= r_a_d[33];
            r_b_dmag <= r_a_d[33] ? w_b_dneg[DW1-1:0] : r_a_d[DW1-1:0];
            r_b_y2s  <= n_b_y2s;
            r_b_x2   <= r_a_x2;

            r_c_tmag <= r_b_t[51] ? w_c_tneg[NW1-1:0] : r_b_t[NW1-1:0];
            r_c_sgn  <= r_b_t[51] ^ r_b_dsgn;
            r_c_dmag <= r_b_dmag;
            r_c_y2s  <= r_b_y2s;
            r_c_x2   <= r_b_x2;

            r_e_s    <= w_d1_sgn ? -w_e_mag : w_e_mag;
            r_e_y2s  <= w_d1_y2s;
            r_e_x2   <= w_d1_x2;

            r_f_p0   <= w_f_p0;
            r_f_p1   <= w_f_p1[31:0];
            r_f_p2   <= w_f_p2[31:0];
            r_f_y2s  <= r_e_y2s;
            r_f_s    <= r_e_s[31:0];

            r_g_u    <= n_g_u;
            r_g_s    <= r_f_s;

            r_h_umag <= r_g_u[63] ? -r_g_u : r_g_u;
            r_h_usgn <= r_g_u[63];
            r_h_s    <= r_g_s;

            for (int k = 0; k < ND; k++) begin
                r_p_v[k]   <= w_q_v[k];
                r_p_q[k]   <= w_q_prod[k][tpc_pkg::OFFSET_SHIFT +: 16];
                r_p_num[k] <= w_q_num[k];
                r_p_quo[k] <= w_q_quo[k];
                r_p_sgn[k] <= w_q_sgn[k];
                r_p_s[k]   <= w_q_s[k];

                r_r_rem[k] <= w_r_sub[k][DW2-1:0];
                r_r_num[k] <= r_p_num[k];
                r_r_quo[k] <= {r_p_quo[k][15:0], r_p_q[k]};
                r_r_sgn[k] <= r_p_sgn[k];
                r_r_s[k]   <= r_p_s[k];
            end

            r_o_gain <= r_r_s[ND-1];
            r_o_off  <= n_o_off;
        end
    end

    assign o_m_axis_tvalid = r_o_vld;
    assign o_m_axis_tdata  = {r_o_off, r_o_gain};

`ifndef SYNTH
    // patched span is never 0 or +-1
    a_span_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_vld |-> (r_b_dmag >= DW1'(2)))
        else $error("patched span magnitude below 2");

    // slope divider remainder below divisor
    a_rem1_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_d1_vld |-> (w_d1_rem < w_d1_dmag))
        else $error("slope remainder not below span");

    // offset divide remainder below 10000
    a_rem2_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_r_vld[ND-1] |-> (r_r_rem[ND-1] < DW2'(tpc_pkg::OFFSET_DIV)))
        else $error("offset remainder out of range");

    // output word holds while the master stalls
    a_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_vld && !i_m_axis_tready) |=>
            ($stable(r_o_vld) && $stable(r_o_gain) && $stable(r_o_off)))
        else $error("pipeline moved during stall");
`endif

endmodule
